// ===== design/bpm_pkg.sv =====
// Shared types, constants and operation codes of the bond presence matcher.
package bpm_pkg;

  // Table capacity and derived widths
  localparam int MAX_BONDS = 64;
  localparam int IDX_W     = (MAX_BONDS > 1) ? $clog2(MAX_BONDS) : 1;
  localparam int ATOM_W    = 20;
  localparam int PRES_W    = 64;
  localparam int FRAME_W   = 16;
  localparam int CNT_W     = 7;

  // Operation codes
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_REF   = 2'd1;
  localparam logic [1:0] OP_FRAME = 2'd2;
  localparam logic [1:0] OP_END   = 2'd3;

  typedef struct packed {
    logic [1:0]        operation;
    logic [ATOM_W-1:0] hydrogen_id;
    logic [ATOM_W-1:0] acceptor_id;
  } in_data_t;

  typedef struct packed {
    logic [PRES_W-1:0]  presence_bits;
    logic [FRAME_W-1:0] frame_index;
    logic [CNT_W-1:0]   reference_count;
    logic               overflow;
  } out_data_t;

  // Item as it travels down the row of cells
  typedef struct packed {
    logic               valid;
    logic [1:0]         op;
    logic [ATOM_W-1:0]  hyd;
    logic [ATOM_W-1:0]  acc;
    logic               wr;
    logic [IDX_W-1:0]   slot;
    logic [CNT_W-1:0]   cnt;
    logic [FRAME_W-1:0] frame;
    logic               ovf;
    logic [PRES_W-1:0]  presence;
  } cell_item_t;

endpackage

// ===== design/bpm_cell.sv =====
// One cell of the matching row: holds one reference bond and its presence bit.
module bpm_cell (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [bpm_pkg::IDX_W-1:0] cell_idx,
  input  bpm_pkg::cell_item_t      item_in,
  output bpm_pkg::cell_item_t      item_out
);
  import bpm_pkg::*;

  cell_item_t        item_r, item_nxt;
  logic [ATOM_W-1:0] hyd_r, hyd_nxt;
  logic [ATOM_W-1:0] acc_r, acc_nxt;
  logic              pres_r, pres_nxt;
  logic              in_use;
  logic              hit;

  // Entry takes part in matching only below the count tagged on the item
  assign in_use = CNT_W'(cell_idx) < item_in.cnt;
  assign hit    = in_use && (hyd_r == item_in.hyd) && (acc_r == item_in.acc);

  // Act on the passing item and forward it
  always_comb begin
    item_nxt = item_in;
    hyd_nxt  = hyd_r;
    acc_nxt  = acc_r;
    pres_nxt = pres_r;
    if (item_in.valid) begin
      case (item_in.op)
        OP_CLEAR: pres_nxt = 1'b0;
        OP_REF: begin
          if (item_in.wr && (item_in.slot == cell_idx)) begin
            hyd_nxt  = item_in.hyd;
            acc_nxt  = item_in.acc;
            pres_nxt = 1'b1;
          end
        end
        OP_FRAME: begin
          if (hit) begin
            pres_nxt = 1'b1;
          end
        end
        OP_END: begin
          item_nxt.presence[cell_idx] = pres_r;
          pres_nxt = 1'b0;
        end
        default: pres_nxt = pres_r;
      endcase
    end
  end

  // Hold control bits under reset, entry payload needs none
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_r.valid <= 1'b0;
      pres_r       <= 1'b0;
    end else begin
      item_r.valid <= item_nxt.valid;
      pres_r       <= pres_nxt;
    end
    item_r.op       <= item_nxt.op;
    item_r.hyd      <= item_nxt.hyd;
    item_r.acc      <= item_nxt.acc;
    item_r.wr       <= item_nxt.wr;
    item_r.slot     <= item_nxt.slot;
    item_r.cnt      <= item_nxt.cnt;
    item_r.frame    <= item_nxt.frame;
    item_r.ovf      <= item_nxt.ovf;
    item_r.presence <= item_nxt.presence;
    hyd_r           <= hyd_nxt;
    acc_r           <= acc_nxt;
  end

  assign item_out = item_r;

endmodule

// ===== design/bond_presence_matcher_top.sv =====
// Top level of the bond presence matcher: issue logic and the row of cells.
//
// Usage: one command is taken per clock cycle; busy stays low, so start may be
// held high for a continuous stream. Each command walks down a row of
// MAX_BONDS (64) comparing cells, one cell per cycle, and every cell acts on
// it in order, so commands never overtake each other. An end-of-frame command
// collects one presence bit from each cell on its way and shows its result on
// out_data with out_valid high for one cycle as it leaves the last cell; the
// receiver must take it then. Other commands give no result. Table count, frame
// number and overflow flag are kept at the issue point and tagged onto each
// command.
module bond_presence_matcher_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  bpm_pkg::in_data_t  in_data,
  output logic               out_valid,
  output bpm_pkg::out_data_t out_data
);
  import bpm_pkg::*;

  logic [CNT_W-1:0]   entry_count_r, entry_count_nxt;
  logic [FRAME_W-1:0] frame_r, frame_nxt;
  logic               ovf_r, ovf_nxt;
  logic               accept;
  logic               room;
  cell_item_t         issue;
  cell_item_t         chain [MAX_BONDS+1];

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign room   = entry_count_r < CNT_W'(MAX_BONDS);

  // Build the item for the first cell and update issue state
  always_comb begin
    entry_count_nxt = entry_count_r;
    frame_nxt       = frame_r;
    ovf_nxt         = ovf_r;
    issue.valid     = accept;
    issue.op        = in_data.operation;
    issue.hyd       = in_data.hydrogen_id;
    issue.acc       = in_data.acceptor_id;
    issue.wr        = 1'b0;
    issue.slot      = entry_count_r[IDX_W-1:0];
    issue.cnt       = entry_count_r;
    issue.frame     = frame_r;
    issue.ovf       = ovf_r;
    issue.presence  = '0;
    if (accept) begin
      case (in_data.operation)
        OP_CLEAR: begin
          entry_count_nxt = '0;
          frame_nxt       = '0;
          ovf_nxt         = 1'b0;
        end
        OP_REF: begin
          if (room) begin
            issue.wr        = 1'b1;
            entry_count_nxt = entry_count_r + CNT_W'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
        end
        OP_FRAME: frame_nxt = frame_r;
        OP_END:   frame_nxt = frame_r + FRAME_W'(1);
        default:  frame_nxt = frame_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r <= '0;
      frame_r       <= '0;
      ovf_r         <= 1'b0;
    end else begin
      entry_count_r <= entry_count_nxt;
      frame_r       <= frame_nxt;
      ovf_r         <= ovf_nxt;
    end
  end

  // Row of comparing cells
  assign chain[0] = issue;

  for (genvar k = 0; k < MAX_BONDS; k++) begin : g_cell
    bpm_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (IDX_W'(k)),
      .item_in  (chain[k]),
      .item_out (chain[k+1])
    );
  end

  // Present the result of an end-of-frame transfer leaving the row
  assign out_valid                = chain[MAX_BONDS].valid && (chain[MAX_BONDS].op == OP_END);
  assign out_data.presence_bits   = chain[MAX_BONDS].presence;
  assign out_data.frame_index     = chain[MAX_BONDS].frame;
  assign out_data.reference_count = chain[MAX_BONDS].cnt;
  assign out_data.overflow        = chain[MAX_BONDS].ovf;

  // Checks on issue state and results
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    entry_count_r <= CNT_W'(MAX_BONDS))
    else $error("entry count above capacity");

  a_full_sets_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_data.operation == OP_REF) && !room |=> ovf_r)
    else $error("dropped reference did not raise overflow");

  a_clear_state: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_data.operation == OP_CLEAR) |=>
      (entry_count_r == '0) && (frame_r == '0) && !ovf_r)
    else $error("clear did not reset issue state");

  a_frame_adv: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_data.operation == OP_END) |=> frame_r == $past(frame_r) + FRAME_W'(1))
    else $error("frame number did not advance");

  a_out_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.reference_count <= CNT_W'(MAX_BONDS))
    else $error("result count above capacity");

endmodule

// ===== tb/sv/tb_bond_presence_matcher_top.sv =====
// Self-checking testbench for the bond presence matcher top level.
module tb_bond_presence_matcher_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bpm_pkg::*;

  localparam int RANDOM_ITEMS   = 900;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = MAX_BONDS + 8;
  localparam int RUN_FRAMES     = 300;
  localparam logic [ATOM_W-1:0] ATOM_MAX = {ATOM_W{1'b1}};

  logic      clk     = 1'b0;
  logic      rst_n   = 1'b0;
  logic      start   = 1'b0;
  in_data_t  in_data = '0;
  logic      busy;
  logic      out_valid;
  out_data_t out_data;

  bond_presence_matcher_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predicted block state
  logic [ATOM_W-1:0]  tbl_hyd [MAX_BONDS];
  logic [ATOM_W-1:0]  tbl_acc [MAX_BONDS];
  logic [CNT_W-1:0]   tbl_count  = '0;
  logic [PRES_W-1:0]  frame_bits = '0;
  logic [FRAME_W-1:0] frame_num  = '0;
  logic               dropped    = 1'b0;

  out_data_t expected_frames [$];
  out_data_t want;

  // Bonds sent since the last clear, for building frame bonds
  logic [ATOM_W-1:0] sent_hyd [$];
  logic [ATOM_W-1:0] sent_acc [$];

  int   error_count     = 0;
  int   n_commands      = 0;
  int   frames_checked  = 0;
  int   overflow_frames = 0;
  int   full_frames     = 0;
  int   stall_cycles    = 0;
  logic burst_mode      = 1'b0;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] exp_val);
    $display("MISMATCH %s at %0t ns: got %h, want %h", what, $time, got, exp_val);
    error_count++;
  endtask

  // Update the predicted state for one accepted command
  function automatic void apply_bond_command(input in_data_t c);
    out_data_t r;
    case (c.operation)
      OP_CLEAR: begin
        tbl_count  = '0;
        frame_bits = '0;
        frame_num  = '0;
        dropped    = 1'b0;
      end
      OP_REF: begin
        if (tbl_count < MAX_BONDS) begin
          tbl_hyd[tbl_count[IDX_W-1:0]] = c.hydrogen_id;
          tbl_acc[tbl_count[IDX_W-1:0]] = c.acceptor_id;
          frame_bits[tbl_count]         = 1'b1;
          tbl_count                     = tbl_count + 1'b1;
        end else begin
          dropped = 1'b1;
        end
      end
      OP_FRAME: begin
        for (int k = 0; k < MAX_BONDS; k++) begin
          if (k < tbl_count && tbl_hyd[k] == c.hydrogen_id && tbl_acc[k] == c.acceptor_id)
            frame_bits[k] = 1'b1;
        end
      end
      default: begin
        r.presence_bits   = frame_bits;
        r.frame_index     = frame_num;
        r.reference_count = tbl_count;
        r.overflow        = dropped;
        expected_frames.push_back(r);
        frame_bits = '0;
        frame_num  = frame_num + 1'b1;
      end
    endcase
  endfunction

  // Predict on each input transfer, check each result, watch for a hang
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) begin
        if (expected_frames.size() == 0) begin
          report_mismatch("result with no frame pending", out_data.presence_bits, '0);
        end else begin
          want = expected_frames.pop_front();
          frames_checked++;
          if (want.overflow) overflow_frames++;
          if (want.reference_count == MAX_BONDS) full_frames++;
          if (out_data.presence_bits !== want.presence_bits)
            report_mismatch("presence_bits", out_data.presence_bits, want.presence_bits);
          if (out_data.frame_index !== want.frame_index)
            report_mismatch("frame_index", 64'(out_data.frame_index),
                            64'(want.frame_index));
          if (out_data.reference_count !== want.reference_count)
            report_mismatch("reference_count", 64'(out_data.reference_count),
                            64'(want.reference_count));
          if (out_data.overflow !== want.overflow)
            report_mismatch("overflow", 64'(out_data.overflow), 64'(want.overflow));
        end
      end
      if (start && !busy) begin
        apply_bond_command(in_data);
        n_commands++;
      end
      if ((start && !busy) || out_valid) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  function automatic logic [ATOM_W-1:0] rand_atom();
    return ATOM_W'($urandom());
  endfunction

  // Send one command; hold start until the transfer happens
  task automatic send_cmd(input logic [1:0] op, input logic [ATOM_W-1:0] hyd,
                          input logic [ATOM_W-1:0] acc);
    in_data_t d;
    int       gap;
    d.operation   = op;
    d.hydrogen_id = hyd;
    d.acceptor_id = acc;
    gap = burst_mode ? 0 : $urandom_range(0, 8);
    if (op == OP_CLEAR) begin
      sent_hyd.delete();
      sent_acc.delete();
    end else if (op == OP_REF) begin
      sent_hyd.push_back(hyd);
      sent_acc.push_back(acc);
    end
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= d;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Stop sending and let every pending frame come back
  task automatic drain();
    start <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk);
  endtask

  // Empty table: frame bonds have no effect, end of frame reports no presence bits
  task automatic test_empty_table();
    burst_mode = 1'b0;
    send_cmd(OP_CLEAR, ATOM_MAX, ATOM_MAX);
    send_cmd(OP_FRAME, '0, '0);
    send_cmd(OP_END, '0, '0);
    send_cmd(OP_FRAME, ATOM_MAX, ATOM_MAX);
    send_cmd(OP_END, ATOM_MAX, ATOM_MAX);
    drain();
  endtask

  // References present in their own frame, duplicates, near misses, late refs
  task automatic test_reference_basics();
    burst_mode = 1'b0;
    send_cmd(OP_CLEAR, '0, '0);
    send_cmd(OP_REF, '0, '0);
    send_cmd(OP_REF, ATOM_MAX, ATOM_MAX);
    send_cmd(OP_REF, ATOM_MAX, '0);
    send_cmd(OP_REF, '0, ATOM_MAX);
    send_cmd(OP_REF, '0, '0);
    send_cmd(OP_END, '0, '0);
    send_cmd(OP_FRAME, '0, '0);
    send_cmd(OP_FRAME, ATOM_MAX, '0);
    send_cmd(OP_FRAME, ATOM_MAX, 20'd1);
    send_cmd(OP_FRAME, 20'h7FFFF, ATOM_MAX);
    send_cmd(OP_END, '0, '0);
    send_cmd(OP_END, '0, '0);
    send_cmd(OP_REF, 20'h5A5A5, 20'hA5A5A);
    send_cmd(OP_FRAME, ATOM_MAX, ATOM_MAX);
    send_cmd(OP_END, '0, '0);
    send_cmd(OP_CLEAR, '0, '0);
    send_cmd(OP_END, '0, '0);
    drain();
  endtask

  // Fill the table, overflow it, and check the flag holds until clear
  task automatic test_table_full();
    burst_mode = 1'b1;
    send_cmd(OP_CLEAR, '0, '0);
    repeat (MAX_BONDS) send_cmd(OP_REF, rand_atom(), rand_atom());
    burst_mode = 1'b0;
    repeat (3) send_cmd(OP_REF, rand_atom(), rand_atom());
    send_cmd(OP_END, '0, '0);
    send_cmd(OP_FRAME, sent_hyd[0], sent_acc[0]);
    send_cmd(OP_FRAME, sent_hyd[MAX_BONDS-1], sent_acc[MAX_BONDS-1]);
    // a dropped bond must not match anything
    send_cmd(OP_FRAME, sent_hyd[MAX_BONDS], sent_acc[MAX_BONDS]);
    send_cmd(OP_END, '0, '0);
    send_cmd(OP_END, '0, '0);
    send_cmd(OP_CLEAR, '0, '0);
    send_cmd(OP_END, '0, '0);
    drain();
  endtask

  // Random trajectories: load references, then frames of mostly known bonds
  task automatic test_random_frames();
    int items;
    int n_refs;
    int n_frames;
    int n_bonds;
    int pick;
    int idx;
    items = 0;
    while (items < RANDOM_ITEMS) begin
      burst_mode = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 4) != 0) begin
        send_cmd(OP_CLEAR, rand_atom(), rand_atom());
        items++;
      end
      n_refs = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 70) : $urandom_range(1, 16);
      repeat (n_refs) begin
        pick = $urandom_range(0, 5);
        if (pick == 0 && sent_hyd.size() != 0) begin
          idx = $urandom_range(0, sent_hyd.size() - 1);
          send_cmd(OP_REF, sent_hyd[idx], sent_acc[idx]);
        end else if (pick == 1) begin
          send_cmd(OP_REF, ATOM_W'($urandom_range(0, 3)), ATOM_W'($urandom_range(0, 3)));
        end else begin
          send_cmd(OP_REF, rand_atom(), rand_atom());
        end
        items++;
      end
      n_frames = $urandom_range(1, 5);
      repeat (n_frames) begin
        n_bonds = $urandom_range(0, 12);
        repeat (n_bonds) begin
          pick = $urandom_range(0, 99);
          idx  = (sent_hyd.size() != 0) ? $urandom_range(0, sent_hyd.size() - 1) : -1;
          if (idx < 0 || pick >= 80) begin
            if (pick >= 96) send_cmd(OP_CLEAR, rand_atom(), rand_atom());
            else if (pick >= 93) send_cmd(OP_REF, rand_atom(), rand_atom());
            else send_cmd(OP_FRAME, rand_atom(), rand_atom());
          end else if (pick < 55) begin
            send_cmd(OP_FRAME, sent_hyd[idx], sent_acc[idx]);
          end else if (pick < 70) begin
            // one bit off in one of the two indices
            if ($urandom_range(0, 1))
              send_cmd(OP_FRAME, sent_hyd[idx] ^ (ATOM_W'(1) << $urandom_range(0, ATOM_W-1)),
                       sent_acc[idx]);
            else
              send_cmd(OP_FRAME, sent_hyd[idx],
                       sent_acc[idx] ^ (ATOM_W'(1) << $urandom_range(0, ATOM_W-1)));
          end else begin
            send_cmd(OP_FRAME, sent_acc[idx], sent_hyd[idx]);
          end
          items++;
        end
        send_cmd(OP_END, rand_atom(), rand_atom());
        items++;
      end
    end
    drain();
  endtask

  // Run a long stream of frame ends back to back
  task automatic test_frame_run();
    burst_mode = 1'b1;
    send_cmd(OP_CLEAR, '0, '0);
    send_cmd(OP_REF, 20'h00123, 20'h00456);
    repeat (RUN_FRAMES) send_cmd(OP_END, '0, '0);
    drain();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_table();
    test_reference_basics();
    test_table_full();
    test_random_frames();
    test_frame_run();
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d commands and checked %0d frame results.", n_commands, frames_checked);
    $display("%0d results came from a full table, %0d had dropped references.",
             full_frames, overflow_frames);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches", error_count);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
